// ----- rtl/core/abbd_pkg.sv -----
// ----------------------------------------------------------------------------
// abbd_pkg: bus decoder shared definitions
// Types, address map, result codes and decode functions used by the
// bus decoder, its tile store, sprite store and sweep sequencer.
// ----------------------------------------------------------------------------
package abbd_pkg;

	localparam int ROW_W   = 10;
	localparam int ROWS    = 1 << ROW_W;
	localparam int BYTE_W  = 8;
	localparam int LINE_W  = 9;
	localparam int BANK_W  = 3;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_QUERY = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_SW_A = 2'd0,
		CFG_SW_B = 2'd1,
		CFG_SW_C = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		RG_NONE,
		RG_SW_A,
		RG_SW_B,
		RG_SW_C,
		RG_COINS,
		RG_P1,
		RG_P2,
		RG_SPR_LO,
		RG_SPR_HI,
		RG_VRAM,
		RG_ROM,
		RG_CTRL,
		RG_SND1,
		RG_SND2,
		RG_BANK,
		RG_SCROLL
	} region_t;

	localparam logic [1:0] SND_NONE = 2'd0;
	localparam logic [1:0] SND_ONE  = 2'd1;
	localparam logic [1:0] SND_TWO  = 2'd2;

	localparam logic [1:0] INT_NONE = 2'd0;
	localparam logic [1:0] INT_IRQ  = 2'd1;
	localparam logic [1:0] INT_NMI  = 2'd2;

	localparam logic [LINE_W-1:0] LINE_IRQ = 9'd240;

	localparam logic [15:0] ADDR_CTRL       = 16'h0000;
	localparam logic [15:0] ADDR_SND1       = 16'h0300;
	localparam logic [15:0] ADDR_SND2       = 16'h0400;
	localparam logic [15:0] ADDR_SW_A       = 16'h0500;
	localparam logic [15:0] ADDR_SW_B       = 16'h0600;
	localparam logic [15:0] ADDR_COINS      = 16'h0700;
	localparam logic [15:0] ADDR_P1         = 16'h0701;
	localparam logic [15:0] ADDR_P2         = 16'h0702;
	localparam logic [15:0] ADDR_SW_C       = 16'h0703;
	localparam logic [15:0] ADDR_BANK       = 16'h1800;
	localparam logic [15:0] ADDR_SCROLL     = 16'h2000;
	localparam logic [15:0] ADDR_SPR_LO     = 16'h2800;
	localparam logic [15:0] ADDR_SPR_LO_END = 16'h2BFF;
	localparam logic [15:0] ADDR_SPR_HI     = 16'h3000;
	localparam logic [15:0] ADDR_SPR_HI_END = 16'h33FF;
	localparam logic [15:0] ADDR_VRAM       = 16'h3800;
	localparam logic [15:0] ADDR_VRAM_END   = 16'h3FFF;
	localparam logic [15:0] ADDR_ROM        = 16'h4000;
	localparam logic [15:0] ADDR_TOP        = 16'hFFFF;

	typedef struct packed {
		logic  mark;
		byte_t code;
		byte_t attr;
	} tile_row_t;

	typedef struct packed {
		logic      we_attr;
		logic      we_code;
		logic      we_mark;
		row_t      row;
		tile_row_t data;
	} tile_wr_t;

	typedef struct packed {
		byte_t hi;
		byte_t lo;
	} sprite_row_t;

	typedef struct packed {
		logic        we_lo;
		logic        we_hi;
		row_t        row;
		sprite_row_t data;
	} sprite_wr_t;

	typedef struct packed {
		logic active;
		logic full;
		row_t row;
	} sweep_t;

	function automatic region_t decode_read(input logic [15:0] a);
		region_t r;
		case (a) inside
			ADDR_SW_A:                      r = RG_SW_A;
			ADDR_SW_B:                      r = RG_SW_B;
			ADDR_COINS:                     r = RG_COINS;
			ADDR_P1:                        r = RG_P1;
			ADDR_P2:                        r = RG_P2;
			ADDR_SW_C:                      r = RG_SW_C;
			[ADDR_SPR_LO:ADDR_SPR_LO_END]: r = RG_SPR_LO;
			[ADDR_SPR_HI:ADDR_SPR_HI_END]: r = RG_SPR_HI;
			[ADDR_VRAM:ADDR_VRAM_END]:     r = RG_VRAM;
			[ADDR_ROM:ADDR_TOP]:           r = RG_ROM;
			default:                        r = RG_NONE;
		endcase
		return r;
	endfunction

	function automatic region_t decode_write(input logic [15:0] a);
		region_t r;
		case (a) inside
			[ADDR_SPR_LO:ADDR_SPR_LO_END]: r = RG_SPR_LO;
			[ADDR_SPR_HI:ADDR_SPR_HI_END]: r = RG_SPR_HI;
			[ADDR_VRAM:ADDR_VRAM_END]:     r = RG_VRAM;
			ADDR_CTRL:                      r = RG_CTRL;
			ADDR_SND1:                      r = RG_SND1;
			ADDR_SND2:                      r = RG_SND2;
			ADDR_BANK:                      r = RG_BANK;
			ADDR_SCROLL:                    r = RG_SCROLL;
			default:                        r = RG_NONE;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/arcade_board_bus_decoder.sv -----
// ----------------------------------------------------------------------------
// arcade_board_bus_decoder: main-board bus decoder
// Decodes CPU reads and writes to sprite RAM, video RAM, ports, DIP
// switches and latches; answers tile queries and scanline ticks.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Its result
// is on the output ports for exactly one cycle, marked by done, after
// the stage and output registers; the receiver cannot stall it. Each
// operation has two steps: the synchronous read of the tile and sprite
// stores, then a step to modify, write back and register the result;
// busy stays high during the second step. After reset a clearing pass
// over all 1024 rows holds busy high; a write that changes the palette
// bank holds busy high again while every tile mark is set. screen_flip
// and scroll always show the current latches.
module arcade_board_bus_decoder
	import abbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [9:0]  tile_offset,
	input  logic [8:0]  scan_line,
	input  logic [7:0]  port_coins,
	input  logic [7:0]  port_player_one,
	input  logic [7:0]  port_player_two,
	output logic [7:0]  data_out,
	output logic        rom_read,
	output logic [1:0]  sound_select,
	output logic        tile_dirty,
	output logic [8:0]  tile_code,
	output logic [10:0] tile_color,
	output logic [1:0]  tile_flip,
	output logic [4:0]  tile_column,
	output logic [4:0]  tile_row,
	output logic [1:0]  interrupt,
	output logic        screen_flip,
	output logic [7:0]  scroll
);

	logic              accept;
	op_t               op_in;
	region_t           region_in;
	byte_t             port_in;

	logic              valid_s1;
	op_t               op_s1;
	region_t           region_s1;
	row_t              row_s1;
	logic              hi_s1;
	byte_t             wdata_s1;
	byte_t             port_s1;
	logic [LINE_W-1:0] line_s1;

	byte_t             sw_a_q;
	byte_t             sw_b_q;
	byte_t             sw_c_q;
	logic              flip_q;
	logic              nmi_en_q;
	logic [BANK_W-1:0] bank_q;
	byte_t             scroll_q;

	tile_row_t         tile_rd;
	sprite_row_t       spr_rd;
	tile_wr_t          tile_wr;
	sprite_wr_t        spr_wr;
	sweep_t            sweep;
	logic              bank_kick;
	byte_t             vram_old;
	logic              vram_changed;

	byte_t             data_d;
	logic              rom_d;
	logic [1:0]        snd_d;
	logic              dirty_d;
	logic [8:0]        code_d;
	logic [10:0]       color_d;
	logic [1:0]        flip_d;
	logic [4:0]        column_d;
	logic [4:0]        row_d;
	logic [1:0]        int_d;

	logic              done_q;
	byte_t             data_q;
	logic              rom_q;
	logic [1:0]        snd_q;
	logic              dirty_q;
	logic [8:0]        code_q;
	logic [10:0]       color_q;
	logic [1:0]        flip_q2;
	logic [4:0]        column_q;
	logic [4:0]        row_q;
	logic [1:0]        int_q;

	assign busy      = valid_s1 | sweep.active;
	assign accept    = start & ~busy;
	assign op_in     = op_t'(op);
	assign region_in = (op_in == OP_READ) ? decode_read(address) : decode_write(address);

	always_comb begin
		case (region_in)
			RG_COINS: port_in = port_coins;
			RG_P1:    port_in = port_player_one;
			RG_P2:    port_in = port_player_two;
			default:  port_in = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_in;
			region_s1 <= region_in;
			row_s1    <= (op_in == OP_QUERY) ? tile_offset : address[ROW_W-1:0];
			hi_s1     <= address[ROW_W];
			wdata_s1  <= write_data;
			port_s1   <= port_in;
			line_s1   <= scan_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_a_q <= '1;
			sw_b_q <= '1;
			sw_c_q <= '1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SW_A: sw_a_q <= cfg_data;
				CFG_SW_B: sw_b_q <= cfg_data;
				CFG_SW_C: sw_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	abbd_tile_store u_tile (
		.clk     (clk),
		.rd_en   (accept),
		.rd_row  ((op_in == OP_QUERY) ? tile_offset : address[ROW_W-1:0]),
		.rd_data (tile_rd),
		.wr      (tile_wr)
	);

	abbd_sprite_store u_sprite (
		.clk     (clk),
		.rd_en   (accept),
		.rd_row  (address[ROW_W-1:0]),
		.rd_data (spr_rd),
		.wr      (spr_wr)
	);

	abbd_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (bank_kick),
		.sweep  (sweep)
	);

	assign vram_old     = hi_s1 ? tile_rd.code : tile_rd.attr;
	assign vram_changed = vram_old != wdata_s1;
	assign bank_kick    = valid_s1 && op_s1 == OP_WRITE && region_s1 == RG_BANK
		&& bank_q != wdata_s1[BANK_W-1:0];

	always_comb begin
		tile_wr = '0;
		if (sweep.active) begin
			tile_wr.row       = sweep.row;
			tile_wr.we_mark   = 1'b1;
			tile_wr.we_attr   = sweep.full;
			tile_wr.we_code   = sweep.full;
			tile_wr.data.mark = 1'b1;
		end else if (valid_s1) begin
			tile_wr.row       = row_s1;
			tile_wr.data.attr = wdata_s1;
			tile_wr.data.code = wdata_s1;
			if (op_s1 == OP_QUERY) begin
				tile_wr.we_mark   = 1'b1;
				tile_wr.data.mark = 1'b0;
			end else if (op_s1 == OP_WRITE && region_s1 == RG_VRAM && vram_changed) begin
				tile_wr.we_mark   = 1'b1;
				tile_wr.data.mark = 1'b1;
				tile_wr.we_attr   = ~hi_s1;
				tile_wr.we_code   = hi_s1;
			end
		end
	end

	always_comb begin
		spr_wr = '0;
		if (sweep.active) begin
			spr_wr.row   = sweep.row;
			spr_wr.we_lo = sweep.full;
			spr_wr.we_hi = sweep.full;
		end else if (valid_s1 && op_s1 == OP_WRITE) begin
			spr_wr.row     = row_s1;
			spr_wr.data.lo = wdata_s1;
			spr_wr.data.hi = wdata_s1;
			spr_wr.we_lo   = region_s1 == RG_SPR_LO;
			spr_wr.we_hi   = region_s1 == RG_SPR_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q   <= 1'b0;
			nmi_en_q <= 1'b0;
			bank_q   <= '0;
			scroll_q <= '0;
		end else if (valid_s1 && op_s1 == OP_WRITE) begin
			case (region_s1)
				RG_CTRL: begin
					flip_q   <= wdata_s1[0];
					nmi_en_q <= wdata_s1[1];
				end
				RG_BANK:   bank_q   <= wdata_s1[BANK_W-1:0];
				RG_SCROLL: scroll_q <= ~wdata_s1;
				default: ;
			endcase
		end
	end

	always_comb begin
		data_d   = '0;
		rom_d    = 1'b0;
		snd_d    = SND_NONE;
		dirty_d  = 1'b0;
		code_d   = '0;
		color_d  = '0;
		flip_d   = '0;
		column_d = '0;
		row_d    = '0;
		int_d    = INT_NONE;
		if (valid_s1) begin
			case (op_s1)
				OP_READ: begin
					case (region_s1)
						RG_SW_A:   data_d = sw_a_q;
						RG_SW_B:   data_d = sw_b_q;
						RG_SW_C:   data_d = sw_c_q;
						RG_COINS,
						RG_P1,
						RG_P2:     data_d = port_s1;
						RG_SPR_LO: data_d = spr_rd.lo;
						RG_SPR_HI: data_d = spr_rd.hi;
						RG_VRAM:   data_d = vram_old;
						RG_ROM:    rom_d  = 1'b1;
						default:   data_d = '1;
					endcase
				end
				OP_WRITE: begin
					if (region_s1 == RG_SND1) begin
						data_d = wdata_s1;
						snd_d  = SND_ONE;
					end else if (region_s1 == RG_SND2) begin
						data_d = wdata_s1;
						snd_d  = SND_TWO;
					end
				end
				OP_QUERY: begin
					dirty_d  = tile_rd.mark;
					code_d   = {tile_rd.attr[6], tile_rd.code};
					color_d  = {bank_q, tile_rd.attr[3:0], 4'b0000};
					flip_d   = {tile_rd.attr[4], tile_rd.attr[5]};
					column_d = ~row_s1[9:5];
					row_d    = row_s1[4:0];
				end
				default: begin
					if (line_s1 == LINE_IRQ) begin
						int_d = INT_IRQ;
					end else if (nmi_en_q && line_s1[4:0] == 5'd0) begin
						int_d = INT_NMI;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			snd_q  <= SND_NONE;
			int_q  <= INT_NONE;
		end else begin
			done_q <= valid_s1;
			snd_q  <= snd_d;
			int_q  <= int_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q   <= data_d;
		rom_q    <= rom_d;
		dirty_q  <= dirty_d;
		code_q   <= code_d;
		color_q  <= color_d;
		flip_q2  <= flip_d;
		column_q <= column_d;
		row_q    <= row_d;
	end

	assign done         = done_q;
	assign data_out     = data_q;
	assign rom_read     = rom_q;
	assign sound_select = snd_q;
	assign tile_dirty   = dirty_q;
	assign tile_code    = code_q;
	assign tile_color   = color_q;
	assign tile_flip    = flip_q2;
	assign tile_column  = column_q;
	assign tile_row     = row_q;
	assign interrupt    = int_q;
	assign screen_flip  = flip_q;
	assign scroll       = scroll_q;

`ifndef NO_ASSERTIONS
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		sweep.active |-> !valid_s1)
		else $error("item in flight during row sweep");

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result missing two cycles after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

	a_idle_codes: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (sound_select == SND_NONE && interrupt == INT_NONE))
		else $error("sound or interrupt code without result");
`endif

endmodule

// ----- rtl/core/abbd_tile_store.sv -----
// ----------------------------------------------------------------------------
// abbd_tile_store: video RAM and tile marks
// One row per tile: attribute byte, code byte and dirty mark, with a
// separate write enable for each lane and a registered read port.
// ----------------------------------------------------------------------------
module abbd_tile_store
	import abbd_pkg::*;
(
	input  logic      clk,
	input  logic      rd_en,
	input  row_t      rd_row,
	output tile_row_t rd_data,
	input  tile_wr_t  wr
);

	tile_row_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr.we_attr) begin
			mem[wr.row].attr <= wr.data.attr;
		end
		if (wr.we_code) begin
			mem[wr.row].code <= wr.data.code;
		end
		if (wr.we_mark) begin
			mem[wr.row].mark <= wr.data.mark;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

// ----- rtl/core/abbd_sprite_store.sv -----
// ----------------------------------------------------------------------------
// abbd_sprite_store: sprite RAM
// Both 1K sprite RAMs side by side, one byte lane each, registered read.
// ----------------------------------------------------------------------------
module abbd_sprite_store
	import abbd_pkg::*;
(
	input  logic        clk,
	input  logic        rd_en,
	input  row_t        rd_row,
	output sprite_row_t rd_data,
	input  sprite_wr_t  wr
);

	sprite_row_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr.we_lo) begin
			mem[wr.row].lo <= wr.data.lo;
		end
		if (wr.we_hi) begin
			mem[wr.row].hi <= wr.data.hi;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

// ----- rtl/core/abbd_sweep.sv -----
// ----------------------------------------------------------------------------
// abbd_sweep: row sweep sequencer
// Walks every row once: after reset to clear both stores and set all
// marks, and on a palette bank change to set all marks.
// ----------------------------------------------------------------------------
module abbd_sweep
	import abbd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   kick,
	output sweep_t sweep
);

	localparam row_t ROW_LAST = row_t'(ROWS - 1);

	logic active_q;
	logic full_q;
	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			full_q   <= 1'b1;
			row_q    <= '0;
		end else if (active_q) begin
			row_q <= row_q + row_t'(1);
			if (row_q == ROW_LAST) begin
				active_q <= 1'b0;
				full_q   <= 1'b0;
			end
		end else if (kick) begin
			active_q <= 1'b1;
			full_q   <= 1'b0;
			row_q    <= '0;
		end
	end

	assign sweep.active = active_q;
	assign sweep.full   = full_q;
	assign sweep.row    = row_q;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: bus decoder testbench
// Sends CPU reads and writes, tile queries and scanline ticks through the
// start/busy command port while a local copy of the RAMs, tile marks and
// latches works out each expected result. Every result strobed by done is
// checked field by field against the oldest expected one. A short directed
// sequence is followed by random phases with different DIP switch settings
// and sender idling rates.
// ----------------------------------------------------------------------------
module tb_top;
	import abbd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int PHASE_CMDS = 170;

	typedef struct packed {
		op_t         op;
		logic [15:0] address;
		byte_t       write_data;
		row_t        tile_offset;
		logic [8:0]  scan_line;
		byte_t       port_coins;
		byte_t       port_player_one;
		byte_t       port_player_two;
	} bus_cmd_t;

	typedef struct packed {
		byte_t       data_out;
		logic        rom_read;
		logic [1:0]  sound_select;
		logic        tile_dirty;
		logic [8:0]  tile_code;
		logic [10:0] tile_color;
		logic [1:0]  tile_flip;
		logic [4:0]  tile_column;
		logic [4:0]  tile_row;
		logic [1:0]  interrupt;
		logic        screen_flip;
		byte_t       scroll;
	} board_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	byte_t cfg_data = '0;
	bus_cmd_t cur = '0;
	logic taken = 1'b0;

	logic busy, done;
	byte_t data_out, scroll;
	logic rom_read, tile_dirty, screen_flip;
	logic [1:0] sound_select, tile_flip, interrupt;
	logic [8:0] tile_code;
	logic [10:0] tile_color;
	logic [4:0] tile_column, tile_row;

	bus_cmd_t pending_cmds [$];
	board_result_t results_due [$];
	int idle_pct = 0;
	int errors = 0;
	row_t hot_base = '0;
	int unsigned op_count [4];
	int unsigned dirty_hits = 0;
	int unsigned irq_seen = 0;
	int unsigned nmi_seen = 0;

	byte_t sw_a, sw_b, sw_c;
	byte_t sprite_lo_mem [ROWS];
	byte_t sprite_hi_mem [ROWS];
	byte_t video_mem [2*ROWS];
	logic tile_mark [ROWS];
	logic [BANK_W-1:0] pal_bank;
	byte_t scroll_q;
	logic nmi_en, flip_q;

	arcade_board_bus_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op(cur.op),
		.address(cur.address),
		.write_data(cur.write_data),
		.tile_offset(cur.tile_offset),
		.scan_line(cur.scan_line),
		.port_coins(cur.port_coins),
		.port_player_one(cur.port_player_one),
		.port_player_two(cur.port_player_two),
		.data_out(data_out),
		.rom_read(rom_read),
		.sound_select(sound_select),
		.tile_dirty(tile_dirty),
		.tile_code(tile_code),
		.tile_color(tile_color),
		.tile_flip(tile_flip),
		.tile_column(tile_column),
		.tile_row(tile_row),
		.interrupt(interrupt),
		.screen_flip(screen_flip),
		.scroll(scroll)
	);

	always #6 clk = ~clk;

	function automatic board_result_t decode_access(bus_cmd_t c);
		board_result_t r;
		byte_t attr;
		r = '0;
		if (c.op == OP_READ) begin
			if (c.address == ADDR_SW_A) r.data_out = sw_a;
			else if (c.address == ADDR_SW_B) r.data_out = sw_b;
			else if (c.address == ADDR_COINS) r.data_out = c.port_coins;
			else if (c.address == ADDR_P1) r.data_out = c.port_player_one;
			else if (c.address == ADDR_P2) r.data_out = c.port_player_two;
			else if (c.address == ADDR_SW_C) r.data_out = sw_c;
			else if (c.address >= ADDR_SPR_LO && c.address <= ADDR_SPR_LO_END)
				r.data_out = sprite_lo_mem[c.address[9:0]];
			else if (c.address >= ADDR_SPR_HI && c.address <= ADDR_SPR_HI_END)
				r.data_out = sprite_hi_mem[c.address[9:0]];
			else if (c.address >= ADDR_VRAM && c.address <= ADDR_VRAM_END)
				r.data_out = video_mem[c.address[10:0]];
			else if (c.address >= ADDR_ROM) r.rom_read = 1'b1;
			else r.data_out = 8'hff;
		end else if (c.op == OP_WRITE) begin
			if (c.address >= ADDR_SPR_LO && c.address <= ADDR_SPR_LO_END)
				sprite_lo_mem[c.address[9:0]] = c.write_data;
			else if (c.address >= ADDR_SPR_HI && c.address <= ADDR_SPR_HI_END)
				sprite_hi_mem[c.address[9:0]] = c.write_data;
			else if (c.address >= ADDR_VRAM && c.address <= ADDR_VRAM_END) begin
				if (video_mem[c.address[10:0]] != c.write_data) begin
					tile_mark[c.address[9:0]] = 1'b1;
					video_mem[c.address[10:0]] = c.write_data;
				end
			end else if (c.address == ADDR_CTRL) begin
				flip_q = c.write_data[0];
				nmi_en = c.write_data[1];
			end else if (c.address == ADDR_SND1) begin
				r.data_out = c.write_data;
				r.sound_select = SND_ONE;
			end else if (c.address == ADDR_SND2) begin
				r.data_out = c.write_data;
				r.sound_select = SND_TWO;
			end else if (c.address == ADDR_BANK) begin
				if (pal_bank != c.write_data[2:0]) begin
					pal_bank = c.write_data[2:0];
					for (int i = 0; i < ROWS; i++) tile_mark[i] = 1'b1;
				end
			end else if (c.address == ADDR_SCROLL) begin
				scroll_q = ~c.write_data;
			end
		end else if (c.op == OP_QUERY) begin
			attr = video_mem[{1'b0, c.tile_offset}];
			r.tile_dirty = tile_mark[c.tile_offset];
			tile_mark[c.tile_offset] = 1'b0;
			r.tile_code = {attr[6], video_mem[{1'b1, c.tile_offset}]};
			r.tile_color = {pal_bank, attr[3:0], 4'b0000};
			r.tile_flip = {attr[4], attr[5]};
			r.tile_column = ~c.tile_offset[9:5];
			r.tile_row = c.tile_offset[4:0];
		end else begin
			if (c.scan_line == LINE_IRQ) r.interrupt = INT_IRQ;
			else if (nmi_en && c.scan_line[4:0] == 5'd0) r.interrupt = INT_NMI;
		end
		r.screen_flip = flip_q;
		r.scroll = scroll_q;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// transfer on start && !busy; results are sampled before the edge updates them
	always @(posedge clk) begin
		board_result_t want;
		if (done) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: result with none expected, data_out %0d", $time, data_out);
				errors++;
			end else begin
				want = results_due.pop_front();
				check_field("data_out", want.data_out, data_out);
				check_field("rom_read", want.rom_read, rom_read);
				check_field("sound_select", want.sound_select, sound_select);
				check_field("tile_dirty", want.tile_dirty, tile_dirty);
				check_field("tile_code", want.tile_code, tile_code);
				check_field("tile_color", want.tile_color, tile_color);
				check_field("tile_flip", want.tile_flip, tile_flip);
				check_field("tile_column", want.tile_column, tile_column);
				check_field("tile_row", want.tile_row, tile_row);
				check_field("interrupt", want.interrupt, interrupt);
				check_field("screen_flip", want.screen_flip, screen_flip);
				check_field("scroll", want.scroll, scroll);
				if (want.tile_dirty) dirty_hits++;
				if (want.interrupt == INT_IRQ) irq_seen++;
				if (want.interrupt == INT_NMI) nmi_seen++;
			end
		end
		if (arst_n && start && !busy) begin
			results_due.insert(results_due.size(), decode_access(cur));
			op_count[cur.op]++;
		end
		taken <= arst_n && start && !busy;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur <= pending_cmds.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_cmd(op_t o, logic [15:0] a, byte_t wd, row_t off, logic [8:0] ln);
		bus_cmd_t c;
		c.op = o;
		c.address = a;
		c.write_data = wd;
		c.tile_offset = off;
		c.scan_line = ln;
		c.port_coins = byte_t'($urandom);
		c.port_player_one = byte_t'($urandom);
		c.port_player_two = byte_t'($urandom);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	function automatic row_t pick_row();
		if ($urandom_range(9) < 7) return hot_base + row_t'($urandom_range(15));
		return row_t'($urandom);
	endfunction

	function automatic byte_t pick_byte();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h5a;
			default: return byte_t'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_address(logic writing);
		logic [15:0] a;
		case ($urandom_range(15))
			0: a = ADDR_CTRL;
			1: a = ADDR_SND1;
			2: a = ADDR_SND2;
			3: a = ADDR_SW_A;
			4: a = ADDR_SW_B;
			5: a = ADDR_COINS + 16'($urandom_range(3));
			6: a = ($urandom_range(3) == 0) ? ADDR_BANK : ADDR_VRAM + 16'(pick_row());
			7: a = ADDR_SCROLL;
			8, 9: a = ADDR_SPR_LO + 16'(pick_row());
			10: a = ADDR_SPR_HI + 16'(pick_row());
			11, 12, 13: a = ADDR_VRAM + {5'd0, 1'($urandom), pick_row()};
			14: a = 16'($urandom_range(ADDR_ROM, ADDR_TOP));
			default: a = 16'($urandom);
		endcase
		// keep stray random writes from hitting the bank latch too often
		if (writing && a == ADDR_BANK && $urandom_range(1) == 0) a = ADDR_SCROLL;
		return a;
	endfunction

	task automatic add_random_cmds(int count);
		int pick;
		logic [8:0] ln;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			case ($urandom_range(3))
				0: ln = LINE_IRQ;
				1: ln = {4'($urandom), 5'd0};
				default: ln = 9'($urandom);
			endcase
			if (pick < 30)
				push_cmd(OP_READ, pick_address(1'b0), byte_t'($urandom), row_t'($urandom), ln);
			else if (pick < 70)
				push_cmd(OP_WRITE, pick_address(1'b1), pick_byte(), row_t'($urandom), ln);
			else if (pick < 90)
				push_cmd(OP_QUERY, 16'($urandom), byte_t'($urandom), pick_row(), ln);
			else
				push_cmd(OP_TICK, 16'($urandom), byte_t'($urandom), row_t'($urandom), ln);
		end
	endtask

	task automatic write_switch(logic [1:0] idx, byte_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SW_A: sw_a = value;
			CFG_SW_B: sw_b = value;
			CFG_SW_C: sw_c = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || start || results_due.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sw_a = 8'hff;
		sw_b = 8'hff;
		sw_c = 8'hff;
		for (int i = 0; i < ROWS; i++) begin
			sprite_lo_mem[i] = '0;
			sprite_hi_mem[i] = '0;
			video_mem[i] = '0;
			video_mem[i+ROWS] = '0;
			tile_mark[i] = 1'b1;
		end
		pal_bank = '0;
		scroll_q = '0;
		nmi_en = 1'b0;
		flip_q = 1'b0;
		for (int i = 0; i < 4; i++) op_count[i] = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		idle_pct = 0;
		push_cmd(OP_READ, ADDR_SW_A, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_SW_B, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_SW_C, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_COINS, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_ROM, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_TOP, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_READ, 16'h0001, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_SPR_LO_END, 8'ha5, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_SPR_LO_END, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_SPR_HI, 8'h3c, 10'd0, 9'd0);
		push_cmd(OP_READ, ADDR_SPR_HI, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_VRAM, 8'h7f, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_VRAM + 16'h0400, 8'hff, 10'd0, 9'd0);
		push_cmd(OP_QUERY, 16'h0000, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_VRAM + 16'h0400, 8'hff, 10'd0, 9'd0);
		push_cmd(OP_QUERY, 16'h0000, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_QUERY, 16'h0000, 8'h00, 10'd1023, 9'd0);
		push_cmd(OP_WRITE, ADDR_CTRL, 8'h03, 10'd0, 9'd0);
		push_cmd(OP_TICK, 16'h0000, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_TICK, 16'h0000, 8'h00, 10'd0, LINE_IRQ);
		push_cmd(OP_TICK, 16'h0000, 8'h00, 10'd0, 9'd511);
		push_cmd(OP_WRITE, ADDR_SND1, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_SND2, 8'hff, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_SCROLL, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_BANK, 8'hff, 10'd0, 9'd0);
		push_cmd(OP_QUERY, 16'h0000, 8'h00, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_TOP, 8'h12, 10'd0, 9'd0);
		push_cmd(OP_WRITE, ADDR_CTRL, 8'h00, 10'd0, 9'd64);
		push_cmd(OP_TICK, 16'h0000, 8'h00, 10'd0, 9'd64);
		wait_idle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					write_switch(CFG_SW_A, 8'h00);
					write_switch(CFG_SW_B, 8'h00);
					write_switch(CFG_SW_C, 8'h00);
					write_switch(CFG_UNUSED, 8'h5a);
				end
				1: begin
					idle_pct = 87;
					write_switch(CFG_SW_A, 8'hff);
					write_switch(CFG_SW_B, 8'hff);
					write_switch(CFG_SW_C, 8'hff);
				end
				2: begin
					idle_pct = 0;
					write_switch(CFG_SW_A, byte_t'($urandom));
					write_switch(CFG_SW_B, byte_t'($urandom));
					write_switch(CFG_SW_C, byte_t'($urandom));
					write_switch(CFG_UNUSED, byte_t'($urandom));
				end
				default: begin
					idle_pct = 27;
					write_switch(CFG_SW_A, byte_t'($urandom));
					write_switch(CFG_SW_C, 8'h81);
				end
			endcase
			hot_base = row_t'($urandom_range(ROWS - 16));
			add_random_cmds(PHASE_CMDS);
			wait_idle();
		end

		$display("Covered %0d reads, %0d writes, %0d tile queries, %0d scanline ticks",
			op_count[OP_READ], op_count[OP_WRITE], op_count[OP_QUERY], op_count[OP_TICK]);
		$display("over five switch settings; %0d dirty tiles, %0d IRQs, %0d NMIs seen",
			dirty_hits, irq_seen, nmi_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", results_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
